// File: hdl/tile_sprite_bitplane_renderer_assert.svh
// ----------------------------------------------------------------------------
// tile sprite bitplane renderer assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef TILE_SPRITE_BITPLANE_RENDERER_ASSERT_SVH
`define TILE_SPRITE_BITPLANE_RENDERER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge outside reset
`define TSBR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition at one edge that implies another at the next edge
`define TSBR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);

`else

`define TSBR_ASSERT(label, prop, msg)
`define TSBR_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// File: hdl/tsbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbr_pkg
// types, codes and field positions shared by the renderer modules
// ----------------------------------------------------------------------------
package tsbr_pkg;

   // default geometry
   localparam int SCREEN_WIDTH_DEF  = 256;
   localparam int SCREEN_HEIGHT_DEF = 256;
   localparam int PLANE_BYTES_DEF   = 8192;

   localparam int NUM_PLANES  = 3;
   localparam int QUEUE_DEPTH = 4;

   // request kinds
   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_TILE   = 2'd1;
   localparam logic [1:0] REQ_SPRITE = 2'd2;

   // sprite attribute decode
   localparam logic [7:0] SPRITE_NONE   = 8'hFF;
   localparam logic [7:0] SPRITE_X_NONE = 8'hFF;
   localparam logic [9:0] SPRITE_Y_BASE = 10'd240;
   localparam int         ATTR_FLIP_Y   = 7;
   localparam int         ATTR_FLIP_X   = 6;

   localparam logic [4:0] SPRITE_LAST_ROW = 5'd31;
   localparam logic [2:0] TILE_LAST_ROW   = 3'd7;

   // request tdata layout
   localparam int REQ_TDATA_W = 64;
   localparam int RQ_ADDR_LO  = 0;
   localparam int RQ_DATA_LO  = 15;
   localparam int RQ_CODE_LO  = 23;
   localparam int RQ_X_LO     = 33;
   localparam int RQ_Y_LO     = 41;
   localparam int RQ_FX_BIT   = 49;
   localparam int RQ_FY_BIT   = 50;
   localparam int RQ_PAL_LO   = 51;
   localparam int RQ_ATTR_LO  = 55;

   // result tdata layout
   localparam int RSP_TDATA_W = 88;
   localparam int RSP_USED_W  = 83;

   typedef struct packed {
      logic [1:0]        kind;
      logic [14:0]       rom_address;
      logic [7:0]        rom_data;
      logic [9:0]        code;
      logic [8:0]        x0;
      logic signed [9:0] y0;
      logic              flip_x;
      logic              flip_y;
      logic [3:0]        palette;
   } cmd_type;

endpackage

// File: hdl/tsbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbr_front
// accepts request items, drops ignored ones, decodes sprites into render commands
// ----------------------------------------------------------------------------
module tsbr_front
   import tsbr_pkg::*;
(
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   q_full,
   output logic                   push,
   output cmd_type                push_cmd
);

   logic [7:0] num_byte;
   logic [7:0] x_byte;
   logic [7:0] y_byte;
   logic [7:0] attr;
   logic       keep;

   assign req_tready = !q_full;

   always_comb begin
      num_byte = req_tdata[RQ_CODE_LO +: 8];
      x_byte   = req_tdata[RQ_X_LO +: 8];
      y_byte   = req_tdata[RQ_Y_LO +: 8];
      attr     = req_tdata[RQ_ATTR_LO +: 8];

      push_cmd.kind        = req_tuser;
      push_cmd.rom_address = req_tdata[RQ_ADDR_LO +: 15];
      push_cmd.rom_data    = req_tdata[RQ_DATA_LO +: 8];
      push_cmd.code        = req_tdata[RQ_CODE_LO +: 10];
      push_cmd.x0          = {1'b0, x_byte};
      push_cmd.y0          = {2'b00, y_byte};
      push_cmd.flip_x      = req_tdata[RQ_FX_BIT];
      push_cmd.flip_y      = req_tdata[RQ_FY_BIT];
      push_cmd.palette     = req_tdata[RQ_PAL_LO +: 4];
      keep                 = 1'b0;

      unique case (req_tuser)
         REQ_LOAD, REQ_TILE: begin
            keep = 1'b1;
         end
         REQ_SPRITE: begin
            // a sprite is four tiles starting at code num*4, placed at 240 - y
            keep = (num_byte != SPRITE_NONE) && (x_byte != SPRITE_X_NONE)
                   && (y_byte != 8'd0);
            push_cmd.code    = {num_byte, 2'b00};
            push_cmd.y0      = SPRITE_Y_BASE - {2'b00, y_byte};
            push_cmd.flip_x  = attr[ATTR_FLIP_X];
            push_cmd.flip_y  = attr[ATTR_FLIP_Y];
            push_cmd.palette = attr[3:0];
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_tvalid && !q_full && keep;

endmodule

// File: hdl/tsbr_queue.sv
`timescale 1ns / 1ps
`include "tile_sprite_bitplane_renderer_assert.svh"
// ----------------------------------------------------------------------------
// tsbr_queue
// short command queue between the front and the render back end
// ----------------------------------------------------------------------------
module tsbr_queue
   import tsbr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PW:0]    count_ff, count_in;

   assign full       = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `TSBR_ASSERT(a_no_overflow, !(push && full), "command pushed into a full queue")
   `TSBR_ASSERT(a_no_underflow, !(pop && !head_valid), "command popped from an empty queue")
   `TSBR_ASSERT(a_count_range, count_ff <= (PW+1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

// File: hdl/tsbr_back.sv
`timescale 1ns / 1ps
`include "tile_sprite_bitplane_renderer_assert.svh"
// ----------------------------------------------------------------------------
// tsbr_back
// character rom planes, row sequencer, pixel decode and result register
// ----------------------------------------------------------------------------
module tsbr_back
   import tsbr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int PLANE_BYTES   = PLANE_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  cmd_type                q_cmd,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int PLANE_AW = $clog2(PLANE_BYTES);
   localparam int XW       = (PLANE_AW + 2 > 15) ? PLANE_AW + 2 : 15;
   localparam logic [10:0]        SW_LIM = 11'(SCREEN_WIDTH);
   localparam logic signed [11:0] SH_LIM = 12'(SCREEN_HEIGHT);

   // ---------------- sequencer ----------------
   logic           active_ff, active_in;
   cmd_type        cmd_ff, cmd_in;
   logic [4:0]     cnt_ff, cnt_in;

   logic           s1_valid_ff, s1_valid_in;
   logic           out_valid_ff, out_valid_in;
   logic           out_adv;
   logic           s1_free;
   logic           issue;
   logic           take;
   logic           cur_last;
   logic           is_sprite;
   logic [1:0]     quad;
   logic [2:0]     row_idx;
   logic [2:0]     src_row;
   logic [9:0]     code_q;
   logic [PLANE_AW-1:0] rd_addr;
   logic [9:0]     row_n;
   logic [8:0]     xs_n;

   // rom write decode
   logic [XW-1:0]       wr_full;
   logic [1:0]          wr_plane;
   logic [PLANE_AW-1:0] wr_off;
   logic                wr_en;

   assign out_adv = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign s1_free = !s1_valid_ff || out_adv;
   assign issue   = active_ff && s1_free;

   always_comb begin
      is_sprite = (cmd_ff.kind == REQ_SPRITE);
      quad      = cnt_ff[4:3];
      row_idx   = cnt_ff[2:0];
      src_row   = cmd_ff.flip_y ? ~row_idx : row_idx;
      code_q    = cmd_ff.code + {8'd0, quad};
      rd_addr   = PLANE_AW'({code_q, row_idx});
      // sprite quadrants shift by 8, swapped when the sprite is mirrored
      row_n     = 10'(cmd_ff.y0)
                  + ((is_sprite && (quad[1] ^ cmd_ff.flip_y)) ? 10'd8 : 10'd0)
                  + {7'd0, src_row};
      xs_n      = cmd_ff.x0
                  + ((is_sprite && (quad[0] ^ cmd_ff.flip_x)) ? 9'd8 : 9'd0);
      cur_last  = is_sprite ? (cnt_ff == SPRITE_LAST_ROW) : (row_idx == TILE_LAST_ROW);
   end

   assign take  = q_valid && (!active_ff || (issue && cur_last));
   assign q_pop = take;

   always_comb begin
      wr_full  = XW'(q_cmd.rom_address);
      wr_plane = wr_full[PLANE_AW +: 2];
      wr_off   = wr_full[PLANE_AW-1:0];
      wr_en    = take && (q_cmd.kind == REQ_LOAD) && (wr_plane != 2'd3)
                 && ((wr_full >> (PLANE_AW + 2)) == '0);
   end

   always_comb begin
      active_in = active_ff;
      cmd_in    = cmd_ff;
      cnt_in    = cnt_ff;
      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
         if (cur_last) begin
            active_in = 1'b0;
         end
      end
      if (take && (q_cmd.kind != REQ_LOAD)) begin
         active_in = 1'b1;
         cmd_in    = q_cmd;
         cnt_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   // ---------------- rom planes ----------------
   logic [7:0] rd_ff [NUM_PLANES];

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
      logic [7:0] rom_mem [PLANE_BYTES];
      always_ff @(posedge clock) begin
         if (wr_en && (wr_plane == 2'(p))) begin
            rom_mem[wr_off] <= q_cmd.rom_data;
         end
         if (issue) begin
            rd_ff[p] <= rom_mem[rd_addr];
         end
      end
   end

   // ---------------- read stage ----------------
   logic signed [9:0] s1_row_ff;
   logic [8:0]        s1_xs_ff;
   logic              s1_fx_ff;
   logic [3:0]        s1_pal_ff;
   logic              s1_last_ff;

   assign s1_valid_in = issue ? 1'b1 : (out_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_row_ff  <= row_n;
         s1_xs_ff   <= xs_n;
         s1_fx_ff   <= cmd_ff.flip_x;
         s1_pal_ff  <= cmd_ff.palette;
         s1_last_ff <= cur_last;
      end
   end

   // ---------------- pixel decode ----------------
   logic signed [11:0] row_w;
   logic               row_ok;
   logic [2:0]         bit_sel;
   logic [2:0]         pat;
   logic [10:0]        col;
   logic [7:0]         mask_n;
   logic [55:0]        colors_n;

   always_comb begin
      row_w    = 12'(s1_row_ff);
      row_ok   = !row_w[11] && (row_w < SH_LIM);
      mask_n   = '0;
      colors_n = '0;
      bit_sel  = '0;
      pat      = '0;
      col      = '0;
      for (int k = 0; k < 8; k++) begin
         // leftmost screen pixel is the msb unless mirrored
         bit_sel = s1_fx_ff ? 3'(k) : 3'(7 - k);
         pat     = {rd_ff[2][bit_sel], rd_ff[1][bit_sel], rd_ff[0][bit_sel]};
         col     = 11'(s1_xs_ff) + 11'(k);
         if ((pat != 3'd0) && row_ok && (col < SW_LIM)) begin
            mask_n[k]         = 1'b1;
            colors_n[7*k +: 7] = {s1_pal_ff, pat};
         end
      end
   end

   // ---------------- result register ----------------
   logic [9:0]  out_row_ff;
   logic [8:0]  out_xs_ff;
   logic [7:0]  out_mask_ff;
   logic [55:0] out_colors_ff;
   logic        out_last_ff;

   assign out_valid_in = out_adv ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         out_row_ff    <= s1_row_ff;
         out_xs_ff     <= s1_xs_ff;
         out_mask_ff   <= mask_n;
         out_colors_ff <= colors_n;
         out_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED_W)'(0), out_colors_ff, out_mask_ff,
                        out_xs_ff, out_row_ff};

   `TSBR_ASSERT(a_tile_rows, !(active_ff && (cmd_ff.kind == REQ_TILE) && (cnt_ff[4:3] != 2'd0)), "tile sequenced past eight rows")
   `TSBR_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !out_adv, s1_valid_ff, "row dropped from read stage")
   `TSBR_ASSERT_NEXT(a_last_idle, issue && cur_last && !take, !active_ff, "sequencer busy after last row")

endmodule

// File: hdl/tile_sprite_bitplane_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_sprite_bitplane_renderer
// 3-bit planar tile and sprite renderer with a loadable character rom
//
//   channel  direction  tdata                                  tuser / tlast
//   req_     in         addr,data,code,x,y,fx,fy,pal,attr      tuser: kind
//   rsp_     out        row_y,x_start,write_mask,pixel_colors  tlast: last
//
// one row result per cycle unless rsp_tready stalls, set by the single read
// port of each rom plane: a tile item gives 8 rows, a sprite 32, loads and
// dropped items none. rows pass the read stage and the result register.
// reset clears control state only; rom contents stay undefined until loaded.
// a four-entry command queue accepts items while rows render, until full.
// ----------------------------------------------------------------------------
module tile_sprite_bitplane_renderer
   import tsbr_pkg::*;
#(
   parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
   parameter int PLANE_BYTES   = PLANE_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rom_address, rom_data, tile_code, x_pos, y_pos, flip_x, flip_y,
   // palette, sprite_attr, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // row_y, x_start, write_mask, pixel_colors, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   logic    q_full;
   logic    push;
   cmd_type push_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_cmd;

   tsbr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   tsbr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_cmd)
   );

   tsbr_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .PLANE_BYTES   (PLANE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/tsbr_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsbr_row_checker
// watches the request and row channels of the renderer, keeps its own copy of
// the character rom, works out the rows every draw item must produce and
// compares each row that leaves the block with the oldest one still owed
// ----------------------------------------------------------------------------
module tsbr_row_checker
   import tsbr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tlast,
   output int                     fail_count,
   output int                     rows_outstanding
);

   localparam int ROM_BYTES = NUM_PLANES * PLANE_BYTES_DEF;

   typedef struct packed {
      logic [9:0]  row_y;
      logic [8:0]  x_start;
      logic [7:0]  write_mask;
      logic [55:0] pixel_colors;
      logic        last;
   } pixel_row_type;

   logic [7:0] char_bytes [ROM_BYTES];
   pixel_row_type row_queue [$];

   // one 8x8 tile: eight rows, mask and colors already in screen order
   task automatic predict_tile(input int code, input int x0, input int y0, input bit fx,
                               input bit fy, input logic [3:0] pal, input bit closes_item);
      int r, k, src, row, col, bitpos;
      logic [7:0] p0, p1, p2;
      logic [2:0] pat;
      pixel_row_type entry;
      for (r = 0; r < 8; r++) begin
         src = (code * 8 + r) % PLANE_BYTES_DEF;
         p0 = char_bytes[src];
         p1 = char_bytes[src + PLANE_BYTES_DEF];
         p2 = char_bytes[src + 2 * PLANE_BYTES_DEF];
         row = y0 + (fy ? 7 - r : r);
         entry = '0;
         entry.row_y = row[9:0];
         entry.x_start = x0[8:0];
         for (k = 0; k < 8; k++) begin
            // leftmost source pixel sits in bit 7 of each plane byte
            bitpos = fx ? k : 7 - k;
            pat = {p2[bitpos], p1[bitpos], p0[bitpos]};
            col = x0 + k;
            if (pat != 3'd0 && row >= 0 && row < SCREEN_HEIGHT_DEF && col < SCREEN_WIDTH_DEF) begin
               entry.write_mask[k] = 1'b1;
               entry.pixel_colors[7 * k +: 7] = {pal, pat};
            end
         end
         entry.last = closes_item && (r == 7);
         row_queue.push_back(entry);
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_row_type got, want;
      logic [14:0] addr;
      logic [7:0] num, sx, sy, attr;
      logic fx, fy;
      int base, top_row;
      if (!reset && req_tvalid && req_tready) begin
         case (req_tuser)
            REQ_LOAD: begin
               addr = req_tdata[RQ_ADDR_LO +: 15];
               if (addr < ROM_BYTES)
                  char_bytes[addr] = req_tdata[RQ_DATA_LO +: 8];
            end
            REQ_TILE: begin
               predict_tile(int'(req_tdata[RQ_CODE_LO +: 10]), int'(req_tdata[RQ_X_LO +: 8]),
                            int'(req_tdata[RQ_Y_LO +: 8]), req_tdata[RQ_FX_BIT],
                            req_tdata[RQ_FY_BIT], req_tdata[RQ_PAL_LO +: 4], 1'b1);
            end
            REQ_SPRITE: begin
               num = req_tdata[RQ_CODE_LO +: 8];
               sx = req_tdata[RQ_X_LO +: 8];
               sy = req_tdata[RQ_Y_LO +: 8];
               attr = req_tdata[RQ_ATTR_LO +: 8];
               // empty slot, parked x or y byte of zero: nothing drawn
               if (num != SPRITE_NONE && sx != SPRITE_X_NONE && sy != 8'd0) begin
                  fx = attr[ATTR_FLIP_X];
                  fy = attr[ATTR_FLIP_Y];
                  base = int'(num) * 4;
                  top_row = int'(SPRITE_Y_BASE) - int'(sy);
                  predict_tile(base, int'(sx) + (fx ? 8 : 0), top_row + (fy ? 8 : 0),
                               fx, fy, attr[3:0], 1'b0);
                  predict_tile(base + 1, int'(sx) + (fx ? 0 : 8), top_row + (fy ? 8 : 0),
                               fx, fy, attr[3:0], 1'b0);
                  predict_tile(base + 2, int'(sx) + (fx ? 8 : 0), top_row + (fy ? 0 : 8),
                               fx, fy, attr[3:0], 1'b0);
                  predict_tile(base + 3, int'(sx) + (fx ? 0 : 8), top_row + (fy ? 0 : 8),
                               fx, fy, attr[3:0], 1'b1);
               end
            end
            default: ;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.row_y = rsp_tdata[9:0];
         got.x_start = rsp_tdata[18:10];
         got.write_mask = rsp_tdata[26:19];
         got.pixel_colors = rsp_tdata[82:27];
         got.last = rsp_tlast;
         if (row_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("[%0t] row with none owed: row_y %0d x %0d mask %h colors %h last %b",
                        $realtime, $signed(got.row_y), got.x_start, got.write_mask,
                        got.pixel_colors, got.last);
         end else begin
            want = row_queue.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("[%0t] row mismatch", $realtime);
                  $display("   expected row_y %0d x %0d mask %h colors %h last %b",
                           $signed(want.row_y), want.x_start, want.write_mask,
                           want.pixel_colors, want.last);
                  $display("   actual   row_y %0d x %0d mask %h colors %h last %b",
                           $signed(got.row_y), got.x_start, got.write_mask,
                           got.pixel_colors, got.last);
               end
            end
         end
      end
      rows_outstanding <= row_queue.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives load, tile and sprite items into the renderer with random gaps on
// both channels; only codes whose rom bytes are loaded are ever drawn. a
// directed opening hits flips, clipping edges, dropped sprites and ignored
// loads, then random draws over the loaded codes follow, mixed with rewrites
// ----------------------------------------------------------------------------
module tb_top;
   import tsbr_pkg::*;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         ROM_BYTES    = NUM_PLANES * PLANE_BYTES_DEF;
   localparam int         TILE_CODES   = PLANE_BYTES_DEF / 8;
   localparam int         CYCLE_LIMIT  = 300000;
   localparam int         DRAIN_CYCLES = 64;
   localparam int         RANDOM_DRAWS = 80;
   localparam logic [7:0] PLANE_STRIPES [NUM_PLANES] = '{8'hAA, 8'hCC, 8'hF0};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [1:0]             req_tuser = REQ_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   int fail_count;
   int rows_outstanding;
   int send_idle_pct = 31;
   int recv_idle_pct = 45;
   int cycle_count = 0;
   bit code_loaded [TILE_CODES];
   bit sprite_loaded [256];
   int ready_codes [$];
   int ready_sprites [$];

   always #5 clock = ~clock;

   tile_sprite_bitplane_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   tsbr_row_checker row_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast),
      .fail_count       (fail_count),
      .rows_outstanding (rows_outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** tile_sprite_bitplane_renderer: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // fields a given kind ignores are left random, the pad stays zero
   function automatic logic [REQ_TDATA_W-1:0] random_word();
      logic [REQ_TDATA_W-1:0] w;
      w = {$urandom, $urandom};
      w[REQ_TDATA_W-1:RQ_ATTR_LO+8] = '0;
      return w;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [REQ_TDATA_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_load(input logic [14:0] addr, input logic [7:0] data);
      logic [REQ_TDATA_W-1:0] w;
      w = random_word();
      w[RQ_ADDR_LO +: 15] = addr;
      w[RQ_DATA_LO +: 8] = data;
      send_item(REQ_LOAD, w);
   endtask

   task automatic send_tile(input logic [9:0] code, input logic [7:0] xp, input logic [7:0] yp,
                            input logic fx, input logic fy, input logic [3:0] pal);
      logic [REQ_TDATA_W-1:0] w;
      w = random_word();
      w[RQ_CODE_LO +: 10] = code;
      w[RQ_X_LO +: 8] = xp;
      w[RQ_Y_LO +: 8] = yp;
      w[RQ_FX_BIT] = fx;
      w[RQ_FY_BIT] = fy;
      w[RQ_PAL_LO +: 4] = pal;
      send_item(REQ_TILE, w);
   endtask

   // upper two code bits stay random: a sprite number is only eight bits
   task automatic send_sprite(input logic [7:0] num, input logic [7:0] xp, input logic [7:0] yp,
                              input logic [7:0] attr);
      logic [REQ_TDATA_W-1:0] w;
      w = random_word();
      w[RQ_CODE_LO +: 8] = num;
      w[RQ_X_LO +: 8] = xp;
      w[RQ_Y_LO +: 8] = yp;
      w[RQ_ATTR_LO +: 8] = attr;
      send_item(REQ_SPRITE, w);
   endtask

   task automatic fill_tile_code(input int code);
      int plane, r;
      if (!code_loaded[code]) begin
         for (plane = 0; plane < NUM_PLANES; plane++)
            for (r = 0; r < 8; r++)
               send_load(15'(plane * PLANE_BYTES_DEF + code * 8 + r),
                         ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255)));
         code_loaded[code] = 1'b1;
         ready_codes.push_back(code);
      end
   endtask

   task automatic fill_sprite(input int num);
      int i;
      for (i = 0; i < 4; i++)
         fill_tile_code(num * 4 + i);
      if (!sprite_loaded[num]) begin
         sprite_loaded[num] = 1'b1;
         ready_sprites.push_back(num);
      end
   endtask

   function automatic logic [7:0] pick_coord();
      if ($urandom_range(3) == 0)
         return 8'($urandom_range(255, 240));
      return 8'($urandom_range(255));
   endfunction

   initial begin
      int n, r, plane, pick, code, num;
      logic [7:0] stripe;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // code 0: stripe rows give every pattern value in one row, then an
      // all-transparent row and an all-seven row
      for (plane = 0; plane < NUM_PLANES; plane++) begin
         for (r = 0; r < 8; r++) begin
            if (r < 4)
               stripe = PLANE_STRIPES[plane];
            else if (r == 4)
               stripe = 8'h00;
            else if (r == 5)
               stripe = 8'hFF;
            else
               stripe = 8'($urandom_range(255));
            send_load(15'(plane * PLANE_BYTES_DEF + r), stripe);
         end
      end
      code_loaded[0] = 1'b1;
      ready_codes.push_back(0);
      fill_tile_code(TILE_CODES - 1);

      send_tile(10'd0, 8'd0, 8'd0, 1'b0, 1'b0, 4'h0);
      send_tile(10'd0, 8'd8, 8'd16, 1'b1, 1'b0, 4'hF);
      send_tile(10'd0, 8'd100, 8'd50, 1'b0, 1'b1, 4'h5);
      send_tile(10'd0, 8'd255, 8'd255, 1'b1, 1'b1, 4'hA);
      send_tile(10'h3FF, 8'd250, 8'd252, 1'b0, 1'b0, 4'h3);
      send_tile(10'h3FF, 8'd248, 8'd248, 1'b1, 1'b1, 4'hC);

      // loads past the rom must not alias onto code 0 or code 1023
      send_load(15'(ROM_BYTES), 8'hFF);
      send_load(15'h7FFF, 8'hFF);
      send_tile(10'd0, 8'd0, 8'd0, 1'b0, 1'b0, 4'h1);
      send_tile(10'h3FF, 8'd0, 8'd0, 1'b0, 1'b0, 4'h2);
      send_item(REQ_UNUSED, random_word());

      // rom write followed at once by a draw that reads it
      send_load(15'(PLANE_BYTES_DEF + 3), 8'h5A);
      send_tile(10'd0, 8'd16, 8'd8, 1'b0, 1'b0, 4'h7);

      fill_sprite(0);
      send_sprite(8'd0, 8'd0, 8'd1, 8'h00);
      send_sprite(8'd0, 8'hFE, 8'hFF, 8'hCF);
      send_sprite(8'd0, 8'd120, 8'd16, 8'h40);
      send_sprite(8'd0, 8'd30, 8'd240, 8'h80);
      send_sprite(8'd0, 8'd200, 8'd100, 8'h3F);
      send_sprite(SPRITE_NONE, 8'd10, 8'd10, 8'h00);
      send_sprite(8'd0, SPRITE_X_NONE, 8'd10, 8'h00);
      send_sprite(8'd0, 8'd10, 8'd0, 8'h00);

      for (n = 0; n < RANDOM_DRAWS; n++) begin
         if (n == RANDOM_DRAWS * 35 / 100) begin
            send_idle_pct = 45;
            recv_idle_pct = 31;
         end
         if (n == RANDOM_DRAWS * 70 / 100) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = $urandom_range(99);
         if (pick < 45) begin
            code = ready_codes[$urandom_range(ready_codes.size() - 1)];
            send_tile(10'(code), pick_coord(), pick_coord(), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 4'($urandom_range(15)));
         end else if (pick < 75) begin
            num = ready_sprites[$urandom_range(ready_sprites.size() - 1)];
            send_sprite(8'(num), 8'($urandom_range(254)), 8'($urandom_range(255, 1)),
                        8'($urandom_range(255)));
         end else if (pick < 85) begin
            // rewrite one byte of a code that may be drawn again
            code = ready_codes[$urandom_range(ready_codes.size() - 1)];
            send_load(15'($urandom_range(NUM_PLANES - 1) * PLANE_BYTES_DEF + code * 8
                          + $urandom_range(7)), 8'($urandom_range(255)));
         end else if (pick < 90) begin
            case ($urandom_range(2))
               0: send_sprite(SPRITE_NONE, pick_coord(), pick_coord(), 8'($urandom_range(255)));
               1: send_sprite(8'($urandom_range(255)), SPRITE_X_NONE, pick_coord(),
                              8'($urandom_range(255)));
               default: send_sprite(8'($urandom_range(255)), pick_coord(), 8'd0,
                                    8'($urandom_range(255)));
            endcase
         end else if (pick < 95) begin
            send_load(15'($urandom_range(32767, ROM_BYTES)), 8'($urandom_range(255)));
         end else begin
            send_item(REQ_UNUSED, random_word());
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rows_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("** tile_sprite_bitplane_renderer: PASSED **");
      else
         $display("** tile_sprite_bitplane_renderer: FAILED **");
      $finish;
   end

endmodule
